// ===== hdl/kvd_pkg.sv =====
// Shared types and constants for the key/velocity deframer.
// Depends on nothing; every other file of the block imports it.
package kvd_pkg;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    localparam int unsigned NUM_SOURCES = 3;
    localparam int unsigned SRC_W       = 2;
    localparam int unsigned KEY_W       = 7;
    localparam int unsigned ENTRY_W     = 2 * KEY_W;

    localparam logic [7:0] BYTE_IDLE_LO = 8'h00;
    localparam logic [7:0] HEADER_MIN   = 8'h80;
    localparam logic [7:0] BYTE_IDLE_HI = 8'hFF;

    typedef struct packed {
        opcode_t          opcode;
        logic [SRC_W-1:0] source;
        logic [7:0]       rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_number;
        logic [KEY_W-1:0] velocity;
        logic             key_valid;
        logic             key_dropped;
        logic [3:0]       keys_waiting;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== hdl/key_velocity_deframer.sv =====
// Top level of the key/velocity deframer: per-source pairing and result register.
// Depends on kvd_pkg and kvd_key_fifo.
//
// Usage: each item on the input channel is either a byte from one of three
// scanner sources (opcode OP_BYTE) or a request to pop the oldest key
// (opcode OP_POP). Idle bytes 0x00, 0x80 and 0xFF, and bytes tagged with
// source three, change nothing. Each source holds one byte; a held header
// above 0x80 followed by a data byte below 0x80 becomes a key number and
// velocity that are queued in the shared key FIFO. When the FIFO is full the
// pair is lost and key_dropped is set in that item's result.
// Every input transfer yields exactly one result transfer. The registered result
// appears in the cycle after the input transfer; key data comes from the FIFO's
// registered read port. One item is taken every cycle while the receiver keeps
// up: the input is ready whenever the result register is empty or its content is
// being taken in the same cycle, so a steady stream runs at one transfer per cycle.
// When the receiver stalls, the result register holds its value and the
// input stops accepting until the result is taken. Reset empties the FIFO,
// invalidates the holding bytes and drops any pending result. The FIFO holds up
// to KEY_DEPTH - 1 keys.
module key_velocity_deframer
    import kvd_pkg::*;
#(
    parameter int unsigned KEY_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic [7:0] held_byte_reg  [NUM_SOURCES];
    logic [7:0] held_byte_next [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] held_valid_reg, held_valid_next;

    logic       result_valid_reg;
    logic       popped_reg, popped_next;
    logic       dropped_reg, dropped_next;
    logic [3:0] waiting_reg;

    logic               accept;
    logic               is_byte;
    logic               pair_done;
    logic [7:0]         held_sel;
    logic               held_sel_valid;
    logic [1:0]         src_idx;
    fifo_req_t          fifo_req;
    fifo_stat_t         fifo_stat;
    logic [3:0]         fifo_count_lo;
    logic [ENTRY_W-1:0] fifo_rd_data;
    logic [ENTRY_W-1:0] push_entry;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    // A byte counts only from a real source and when it is not an idle code.
    assign is_byte = (item.opcode == OP_BYTE)
                  && (item.source < SRC_W'(NUM_SOURCES))
                  && (item.rx_byte != BYTE_IDLE_LO)
                  && (item.rx_byte != HEADER_MIN)
                  && (item.rx_byte != BYTE_IDLE_HI);

    assign src_idx        = (item.source < SRC_W'(NUM_SOURCES)) ? item.source : 2'd0;
    assign held_sel       = held_byte_reg[src_idx];
    assign held_sel_valid = held_valid_reg[src_idx];

    assign pair_done = is_byte && held_sel_valid
                    && (held_sel > HEADER_MIN) && (item.rx_byte < HEADER_MIN);

    assign push_entry = {held_sel[KEY_W-1:0], item.rx_byte[KEY_W-1:0]};

    always_comb
    begin
        fifo_req.push   = accept && pair_done && !fifo_stat.full;
        fifo_req.pop    = accept && (item.opcode == OP_POP) && !fifo_stat.empty;
        popped_next     = fifo_req.pop;
        dropped_next    = pair_done && fifo_stat.full;
        held_valid_next = held_valid_reg;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            held_byte_next[i] = held_byte_reg[i];
        end
        // A completed pair consumes the held byte; anything else replaces it.
        if (accept && is_byte)
        begin
            if (pair_done)
            begin
                held_valid_next[src_idx] = 1'b0;
            end
            else
            begin
                held_valid_next[src_idx] = 1'b1;
                held_byte_next[src_idx]  = item.rx_byte;
            end
        end
    end

    kvd_key_fifo #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_key_fifo (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (fifo_req),
        .wr_data       (push_entry),
        .stat          (fifo_stat),
        .count_next_lo (fifo_count_lo),
        .rd_data       (fifo_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            held_byte_reg[i] <= held_byte_next[i];
        end
        if (accept)
        begin
            popped_reg  <= popped_next;
            dropped_reg <= dropped_next;
            waiting_reg <= fifo_count_lo;
        end
    end

    // Popped key data comes straight from the FIFO's registered read port.
    assign result_valid        = result_valid_reg;
    assign result.key_number   = popped_reg ? fifo_rd_data[ENTRY_W-1:KEY_W] : '0;
    assign result.velocity     = popped_reg ? fifo_rd_data[KEY_W-1:0] : '0;
    assign result.key_valid    = popped_reg;
    assign result.key_dropped  = dropped_reg;
    assign result.keys_waiting = waiting_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted item produced no result");

    a_pop_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.key_valid && result.key_dropped))
        else $error("result flags both a pop and a drop");

endmodule

// ===== hdl/kvd_key_fifo.sv =====
// Shared key FIFO: a synchronous memory plus read/write pointers and a fill count.
// Depends on kvd_pkg.
module kvd_key_fifo
    import kvd_pkg::*;
#(
    parameter int unsigned KEY_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  fifo_req_t          req,
    input  logic [ENTRY_W-1:0] wr_data,
    output fifo_stat_t         stat,
    output logic [3:0]         count_next_lo,
    output logic [ENTRY_W-1:0] rd_data
);

    localparam int unsigned AW = $clog2(KEY_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(KEY_DEPTH - 1);

    logic [ENTRY_W-1:0] mem [KEY_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]      count_reg, count_next;
    logic [31:0]        count_wide;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (req.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (req.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (req.push && !req.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (req.pop && !req.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_wide    = 32'(count_next);
    assign count_next_lo = count_wide[3:0];
    assign stat.full     = (count_reg == LAST);
    assign stat.empty    = (count_reg == '0);
    assign rd_data       = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The read register only moves on a pop, so popped data holds while the
    // result waits downstream.
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (req.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        req.push |-> !stat.full)
        else $error("key FIFO written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req.pop |-> !stat.empty)
        else $error("key FIFO read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (req.push && !req.pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not follow a write");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) |-> (count_reg == '0))
        else $error("pointers equal while FIFO holds keys");

endmodule

// ===== tb/kvd_checker.sv =====
// Scoreboard for the key/velocity deframer: watches both channels and checks every result.
// Depends on kvd_pkg; instantiated by tb_key_velocity_deframer beside the block.
module kvd_checker
    import kvd_pkg::*;
#(
    parameter int unsigned KEY_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_ready,
    input  in_item_t  item,
    input  logic      result_valid,
    input  logic      result_ready,
    input  out_item_t result,
    output int        fail_count,
    output int        results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the deframer: one holding byte per source and the key queue.
    logic [7:0]         shadow_held[NUM_SOURCES];
    logic               shadow_held_ok[NUM_SOURCES];
    logic [ENTRY_W-1:0] shadow_keys[KEY_DEPTH];
    int unsigned        wr_ptr;
    int unsigned        rd_ptr;

    out_item_t          owed_results[$];
    out_item_t          want;

    function automatic int unsigned queued_keys();
        return (wr_ptr + KEY_DEPTH - rd_ptr) % KEY_DEPTH;
    endfunction

    // Applies one accepted transfer to the shadow state and returns the result it must cause.
    function automatic out_item_t next_deframer_result(in_item_t it);
        out_item_t   r;
        int unsigned src;
        int unsigned cnt;
        logic [7:0]  b;
        r   = '0;
        src = it.source;
        b   = it.rx_byte;
        if (it.opcode == OP_POP) begin
            if (queued_keys() != 0) begin
                r.key_number = shadow_keys[rd_ptr][ENTRY_W-1:KEY_W];
                r.velocity   = shadow_keys[rd_ptr][KEY_W-1:0];
                r.key_valid  = 1'b1;
                rd_ptr       = (rd_ptr + 1) % KEY_DEPTH;
            end
        end else if (src < NUM_SOURCES && b != BYTE_IDLE_LO && b != HEADER_MIN
                     && b != BYTE_IDLE_HI) begin
            if (shadow_held_ok[src] && shadow_held[src] > HEADER_MIN && b < HEADER_MIN) begin
                if (queued_keys() >= KEY_DEPTH - 1) begin
                    r.key_dropped = 1'b1;
                end else begin
                    shadow_keys[wr_ptr] = {shadow_held[src][KEY_W-1:0], b[KEY_W-1:0]};
                    wr_ptr = (wr_ptr + 1) % KEY_DEPTH;
                end
                shadow_held_ok[src] = 1'b0;
                shadow_held[src]    = '0;
            end else begin
                shadow_held[src]    = b;
                shadow_held_ok[src] = 1'b1;
            end
        end
        cnt            = queued_keys();
        r.keys_waiting = cnt[3:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                shadow_held[i]    = '0;
                shadow_held_ok[i] = 1'b0;
            end
            wr_ptr       = 0;
            rd_ptr       = 0;
            owed_results.delete();
            fail_count   = 0;
            results_owed = 0;
        end else begin
            // Results are retired before new items are queued; an item accepted at this
            // edge cannot have its result on the channel at the same edge.
            if (result_valid && result_ready) begin
                if (owed_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result key %0d vel %0d valid %0b drop %0b keys %0d",
                                 $realtime, result.key_number, result.velocity,
                                 result.key_valid, result.key_dropped, result.keys_waiting);
                end else begin
                    want = owed_results.pop_front();
                    if (result.key_number !== want.key_number
                        || result.velocity !== want.velocity
                        || result.key_valid !== want.key_valid
                        || result.key_dropped !== want.key_dropped
                        || result.keys_waiting !== want.keys_waiting) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result mismatch: expected key %0d vel %0d valid %0b ",
                                      "drop %0b keys %0d, got key %0d vel %0d valid %0b drop %0b ",
                                      "keys %0d"},
                                     $realtime, want.key_number, want.velocity, want.key_valid,
                                     want.key_dropped, want.keys_waiting, result.key_number,
                                     result.velocity, result.key_valid, result.key_dropped,
                                     result.keys_waiting);
                    end
                end
            end
            if (item_valid && item_ready)
                owed_results.push_back(next_deframer_result(item));
            results_owed = owed_results.size();
        end
    end

endmodule

// ===== tb/tb_key_velocity_deframer.sv =====
// Top of the key/velocity deframer testbench: clock, reset, stimulus, receiver and verdict.
// Depends on kvd_pkg, key_velocity_deframer and kvd_checker.
module tb_key_velocity_deframer
    import kvd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned KEY_DEPTH = 16;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    int        fail_count;
    int        results_owed;

    // Count of transfers that do real work (pops and non-idle bytes from a real source).
    // The receiver watches it to decide when to start its long hold-off.
    int unsigned items_sent   = 0;
    bit          sender_calm  = 1'b0;

    key_velocity_deframer #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The checker sees exactly what the block sees and reports failures and what is still owed.
    kvd_checker #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle stretches: mostly none or short, now and then a long one.
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t make_item(opcode_t op, int unsigned src, int unsigned b);
        in_item_t it;
        it.opcode  = op;
        it.source  = src[SRC_W-1:0];
        it.rx_byte = b[7:0];
        return it;
    endfunction

    // Offers one transfer and returns at the edge that accepts it. Valid is only dropped
    // when a gap is inserted, so back-to-back transfers keep valid high without a glitch.
    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = sender_calm ? 0 : idle_span();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (it.opcode == OP_POP || (it.source < NUM_SOURCES && it.rx_byte != BYTE_IDLE_LO
                                    && it.rx_byte != HEADER_MIN && it.rx_byte != BYTE_IDLE_HI))
            items_sent++;
    endtask

    // Receiver: random stalls with calm stretches, plus one long hold-off once the
    // random traffic is under way, so that the result register fills and the block
    // stops taking input while the sender keeps offering.
    initial
    begin
        int unsigned hold;
        int unsigned calm_left;
        bit          calm;
        bit          long_hold_done;
        hold           = 0;
        calm           = 1'b0;
        calm_left      = 150;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && items_sent >= 300)
            begin
                result_ready <= 1'b0;
                repeat (200) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (hold != 0)
            begin
                result_ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0)
                    hold = idle_span();
            end
            if (calm_left == 0)
            begin
                calm      = !calm;
                calm_left = $urandom_range(50, 300);
            end
            else
            begin
                calm_left--;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned pop_pct[8];
        int unsigned stop_at;
        bit          want_data[NUM_SOURCES];
        int unsigned s;
        int unsigned b;
        in_item_t    it;

        pop_pct = '{4, 35, 60, 10, 50, 85, 2, 40};
        for (int i = 0; i < NUM_SOURCES; i++)
            want_data[i] = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A pop with nothing queued must come back empty.
        send_item(make_item(OP_POP, 0, 8'h00));
        // Idle fillers on every source change nothing.
        send_item(make_item(OP_BYTE, 0, BYTE_IDLE_LO));
        send_item(make_item(OP_BYTE, 1, HEADER_MIN));
        send_item(make_item(OP_BYTE, 2, BYTE_IDLE_HI));
        // A header on the fourth source number is ignored.
        send_item(make_item(OP_BYTE, 3, 8'h85));
        // Smallest and largest headers, with data at both extremes.
        send_item(make_item(OP_BYTE, 0, 8'h81));
        send_item(make_item(OP_BYTE, 0, 8'h01));
        send_item(make_item(OP_BYTE, 1, 8'hFE));
        send_item(make_item(OP_BYTE, 1, 8'h7F));
        // An idle byte between header and data leaves the held header in place.
        send_item(make_item(OP_BYTE, 2, 8'hC0));
        send_item(make_item(OP_BYTE, 2, HEADER_MIN));
        send_item(make_item(OP_BYTE, 2, 8'h40));
        // Broken pairs: data without a header, then a header followed by another header.
        send_item(make_item(OP_BYTE, 0, 8'h10));
        send_item(make_item(OP_BYTE, 0, 8'h20));
        send_item(make_item(OP_BYTE, 0, 8'h90));
        send_item(make_item(OP_BYTE, 0, 8'h91));
        send_item(make_item(OP_BYTE, 0, 8'h33));
        // Two sources interleaved byte by byte.
        send_item(make_item(OP_BYTE, 1, 8'hA5));
        send_item(make_item(OP_BYTE, 2, 8'hB6));
        send_item(make_item(OP_BYTE, 1, 8'h15));
        send_item(make_item(OP_BYTE, 2, 8'h26));
        // Drain all six keys in order.
        repeat (6) send_item(make_item(OP_POP, 3, 8'hFF));

        // Random part in phases of different pop rates: the low-rate phases fill the key
        // queue until pairs get dropped, the high-rate ones drain it and hit empty pops.
        // Most bytes follow the header/data rhythm per source; the rest are noise.
        for (int phase = 0; phase < 8; phase++)
        begin
            sender_calm = (phase % 3 == 2);
            stop_at     = items_sent + 106;
            while (items_sent < stop_at)
            begin
                if ($urandom_range(0, 99) < pop_pct[phase])
                begin
                    it = make_item(OP_POP, $urandom_range(0, 3), $urandom_range(0, 255));
                end
                else if ($urandom_range(0, 9) < 8)
                begin
                    s = $urandom_range(0, NUM_SOURCES - 1);
                    if (want_data[s])
                        b = $urandom_range(1, 127);
                    else
                        b = $urandom_range(129, 254);
                    want_data[s] = !want_data[s];
                    it = make_item(OP_BYTE, s, b);
                end
                else
                begin
                    it = make_item(OP_BYTE, $urandom_range(0, 3), $urandom_range(0, 255));
                end
                send_item(it);
            end
        end

        item_valid <= 1'b0;
        @(posedge clk);
        wait (results_owed == 0);
        // Waiting on afterwards catches any stray result.
        repeat (8) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
